>>> sv/cdq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_pkg - shared types and constants of the circular deque
// Operation and status codes, field widths and the controller/datapath link.
// ----------------------------------------------------------------------------
package cdq_pkg;

    localparam int DEPTH_DEF = 64;   // default ring size
    localparam int WORD_W    = 32;   // stored and returned word
    localparam int OP_W      = 3;
    localparam int STATUS_W  = 2;
    localparam int COUNT_W   = 7;    // count_out field
    localparam int IN_TDATA_W  = 40; // op, value, pad
    localparam int OUT_TDATA_W = 48; // value_out, status, count_out, pad

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_DUMP       = 3'd4
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic    push;        // write one word
        logic    pop;         // remove one word, read it out
        logic    front;       // push/pop acts on the front end
        logic    dump_first;  // read the front entry, start the walk
        logic    dump_next;   // read the next entry of the walk
        logic    res_load;    // capture a result into the output register
        t_status res_status;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic empty;
        logic full;
        logic res_last;       // result held is the final one of its request
    } t_dp_sts;

endpackage
`default_nettype wire

>>> sv/cdq_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_dp - ring store datapath of the circular deque
// Word memory, front index, fill count, dump walk index and result register.
// ----------------------------------------------------------------------------
module cdq_dp #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire cdq_pkg::t_dp_cmd                  i_cmd,
    input  wire logic [cdq_pkg::WORD_W-1:0]        i_value,
    output cdq_pkg::t_dp_sts                       o_sts,
    output logic [cdq_pkg::WORD_W-1:0]             o_value_out,
    output logic [cdq_pkg::STATUS_W-1:0]           o_status,
    output logic [cdq_pkg::COUNT_W-1:0]            o_count
);
    import cdq_pkg::*;

    localparam int IW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW:0] DEPTH_X = (CW+1)'(DEPTH);

    // ring position base + off, off below DEPTH
    function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        begin
            sum = (CW+1)'(base) + (CW+1)'(off);
            if (sum >= DEPTH_X) begin
                sum = sum - DEPTH_X;
            end
            return sum[IW-1:0];
        end
    endfunction

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [IW-1:0]     r_front, n_front;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_idx;
    t_status           r_res_status;
    logic [CW-1:0]     r_res_count;
    logic              r_use_mem;
    logic              r_last, n_last;
    logic [IW-1:0]     wr_addr, rd_addr;
    logic              rd_en;

    always_comb begin
        wr_addr = i_cmd.front ? ring_add(r_front, CW'(DEPTH - 1)) : ring_add(r_front, r_count);
        rd_en   = i_cmd.pop | i_cmd.dump_first | i_cmd.dump_next;
        rd_addr = r_front;
        if (i_cmd.pop && !i_cmd.front) begin
            rd_addr = ring_add(r_front, r_count - CW'(1));
        end else if (i_cmd.dump_next) begin
            rd_addr = ring_add(r_front, CW'(r_idx));
        end
    end

    always_comb begin
        n_front = r_front;
        n_count = r_count;
        if (i_cmd.push) begin
            n_count = r_count + CW'(1);
            if (i_cmd.front) begin
                n_front = wr_addr;
            end
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            if (i_cmd.front) begin
                n_front = ring_add(r_front, CW'(1));
            end
        end
    end

    always_comb begin
        n_last = 1'b1;
        if (i_cmd.dump_first) begin
            n_last = (r_count == CW'(1));
        end else if (i_cmd.dump_next) begin
            n_last = (CW'(r_idx) + CW'(1) == r_count);
        end
    end

    // memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_mem[wr_addr] <= i_value;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.dump_first) begin
            r_idx <= IW'(1);
        end else if (i_cmd.dump_next) begin
            r_idx <= r_idx + IW'(1);
        end
        if (i_cmd.res_load) begin
            r_res_status <= i_cmd.res_status;
            r_res_count  <= n_count;
            r_use_mem    <= rd_en;
            r_last       <= n_last;
        end
    end

    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(DEPTH));
    assign o_sts.res_last = r_last;
    assign o_value_out    = r_use_mem ? r_rd_data : '0;
    assign o_status       = r_res_status;
    assign o_count        = COUNT_W'(r_res_count);

endmodule
`default_nettype wire

>>> sv/cdq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_ctrl - request sequencer of the circular deque
// Decodes each request, drives the datapath and holds the result handshake.
// ----------------------------------------------------------------------------
module cdq_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic [cdq_pkg::OP_W-1:0]    i_op,
    output logic                             o_ready,
    output logic                             o_valid,
    input  wire logic                        i_out_ready,
    input  wire cdq_pkg::t_dp_sts            i_sts,
    output cdq_pkg::t_dp_cmd                 o_cmd
);
    import cdq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_OUT  = 2'b10
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.res_status = STS_OK;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    case (i_op)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_OUT;
                            if (i_sts.full) begin
                                o_cmd.res_status = STS_FULL;
                            end else begin
                                o_cmd.push  = 1'b1;
                                o_cmd.front = (i_op == OP_PUSH_FRONT);
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_OUT;
                            if (i_sts.empty) begin
                                o_cmd.res_status = STS_EMPTY;
                            end else begin
                                o_cmd.pop   = 1'b1;
                                o_cmd.front = (i_op == OP_POP_FRONT);
                            end
                        end
                        OP_DUMP: begin
                            o_cmd.res_load = 1'b1;
                            n_state        = S_OUT;
                            if (i_sts.empty) begin
                                o_cmd.res_status = STS_EMPTY;
                            end else begin
                                o_cmd.dump_first = 1'b1;
                            end
                        end
                        default: begin
                            // unused codes: dropped, no result
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    if (i_sts.res_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.dump_next = 1'b1;
                        o_cmd.res_load  = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);

endmodule
`default_nettype wire

>>> sv/circular_deque.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque - double-ended queue of 32-bit words in a ring store
// Push/pop at either end, or dump all entries front to back.
// ----------------------------------------------------------------------------
//  Channel   Dir  Signals            Content (low bit up)
//  s_axis    in   tvalid/tready      tdata: op[2:0], value[34:3], zero pad
//  m_axis    out  tvalid/tready      tdata: value_out[31:0], status[33:32],
//                 tlast                     count_out[40:34], zero pad
//
//  One request in flight at a time: a push or pop is accepted, then its
//  result is offered; a dump offers its entries front to back,
//  one result per cycle while the sink keeps tready high. The single read
//  port of the ring memory sets the dump pace.
//  Reset is synchronous, active low; it empties the deque at once (no sweep).
//  Sink stalls hold the result and, during a dump, pause the walk.
//  Unused op codes are accepted and give no result.
// ----------------------------------------------------------------------------
module circular_deque #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // request stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [cdq_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,  // op, value
    // result stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [cdq_pkg::OUT_TDATA_W-1:0]        o_m_axis_tdata,  // value_out, status, count_out
    output logic                                   o_m_axis_tlast
);
    import cdq_pkg::*;

    t_dp_cmd                cmd;
    t_dp_sts                sts;
    logic [OP_W-1:0]        req_op;
    logic [WORD_W-1:0]      req_value;
    logic [WORD_W-1:0]      res_value;
    logic [STATUS_W-1:0]    res_status;
    logic [COUNT_W-1:0]     res_count;

    assign req_op    = i_s_axis_tdata[OP_W-1:0];
    assign req_value = i_s_axis_tdata[OP_W +: WORD_W];

    // sequencer: only a valid request in the idle state is acted upon
    cdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .i_op        (req_op),
        .o_ready     (o_s_axis_tready),
        .o_valid     (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // ring memory, pointers and the result register
    cdq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (req_value),
        .o_sts       (sts),
        .o_value_out (res_value),
        .o_status    (res_status),
        .o_count     (res_count)
    );

    // pack result; unused top bits are zero
    assign o_m_axis_tdata = {(OUT_TDATA_W - WORD_W - STATUS_W - COUNT_W)'(0),
                             res_count, res_status, res_value};
    assign o_m_axis_tlast = sts.res_last;

endmodule
`default_nettype wire

>>> sv/cdq_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cdq_checker - port-level checks of the circular deque
// Watches the two stream channels only; bound to the top level.
// ----------------------------------------------------------------------------
module cdq_checker #(
    parameter int DEPTH = cdq_pkg::DEPTH_DEF
) (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_s_axis_tready,
    input wire logic                              o_m_axis_tvalid,
    input wire logic                              i_m_axis_tready,
    input wire logic [cdq_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata,
    input wire logic                              o_m_axis_tlast
);
    import cdq_pkg::*;

    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;
    logic [WORD_W-1:0]   res_value;

    assign res_value  = o_m_axis_tdata[WORD_W-1:0];
    assign res_status = o_m_axis_tdata[WORD_W +: STATUS_W];
    assign res_count  = o_m_axis_tdata[WORD_W + STATUS_W +: COUNT_W];

    // one request at a time: never taking input while a result is offered
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_axis_tready && o_m_axis_tvalid))
        else $error("input taken while a result is pending");

    // count never beyond the ring size
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (res_count <= COUNT_W'(DEPTH)))
        else $error("count beyond ring size");

    // error results are single, zero-valued and final
    a_error_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && (res_status == STS_EMPTY || res_status == STS_FULL))
        |-> (res_value == '0 && o_m_axis_tlast))
        else $error("malformed error result");

    // an empty status always reports a zero count
    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && res_status == STS_EMPTY) |-> (res_count == '0))
        else $error("empty result with non-zero count");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready)
        |=> (o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)))
        else $error("stalled result changed");

endmodule

bind circular_deque cdq_checker #(.DEPTH(DEPTH)) u_cdq_checker (.*);
`default_nettype wire
